// ===== hdl/sorted_array_list_store_unit_assert.svh =====
// Assertion macros used by the sorted list store top level.
`ifndef SORTED_ARRAY_LIST_STORE_UNIT_ASSERT_SVH
`define SORTED_ARRAY_LIST_STORE_UNIT_ASSERT_SVH

// Same-cycle implication, checked at every rising clock edge out of reset.
`define SALS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SALS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/sals_pkg.sv =====
// Shared types, codes and sizes for the sorted list store.
package sals_pkg;

  localparam int unsigned DEPTH     = 32;
  localparam int unsigned AW        = $clog2(DEPTH);
  localparam int unsigned CW        = $clog2(DEPTH + 1);
  localparam int unsigned DW        = 32;
  localparam int unsigned MODE_W    = 3;
  localparam int unsigned STAT_W    = 2;
  localparam int unsigned IDX_W     = 6;
  localparam int unsigned S_TDATA_W = 40;
  localparam int unsigned M_TDATA_W = 16;

  typedef enum logic [MODE_W-1:0] {
    MODE_INSERT = 3'd0,
    MODE_UNIQUE = 3'd1,
    MODE_DELETE = 3'd2,
    MODE_LOCATE = 3'd3,
    MODE_CLEAR  = 3'd4
  } mode_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_DUP  = 2'd2,
    ST_MISS = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    IDX_ZERO  = 2'd0,
    IDX_POS   = 2'd1,
    IDX_COUNT = 2'd2
  } idx_sel_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_SCAN,
    S_SCAN_CMP,
    S_DECIDE,
    S_UP_CHK,
    S_UP_WR,
    S_INS,
    S_RUN,
    S_RUN_CMP,
    S_DN_WR,
    S_DN_CHK,
    S_FINISH
  } state_e;

  typedef struct packed {
    logic     load;
    logic     rd_ptr;
    logic     rd_ptr_m1;
    logic     ptr_inc;
    logic     ptr_dec;
    logic     ptr_to_count;
    logic     set_pos;
    logic     wp_from_pos;
    logic     wr_up;
    logic     wr_ins;
    logic     wr_dn;
    logic     count_from_wp;
    logic     clr_count;
    logic     set_res;
    status_e  res_status;
    idx_sel_e res_idx;
    logic     emit;
  } sals_cmd_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              found;
    logic              at_end;
    logic              ge;
    logic              eq;
    logic              full;
    logic              ptr_gt_pos;
    logic              out_free;
  } sals_sts_t;

endpackage

// ===== hdl/sals_datapath.sv =====
// Datapath: entry memory, pointers, count and result registers.
module sals_datapath import sals_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  sals_cmd_t            cmd_i,
  output sals_sts_t            sts_o,
  input  logic [S_TDATA_W-1:0] s_axis_tdata_i,   // mode[2:0], value[34:3]
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  output logic [M_TDATA_W-1:0] m_axis_tdata_o    // status[1:0], index[7:2], count[13:8]
);

  logic [DW-1:0]        mem [DEPTH];
  logic [MODE_W-1:0]    mode_q;
  logic signed [DW-1:0] value_q;
  logic signed [DW-1:0] rdata_q;
  logic [CW-1:0]        count_q, count_d;
  logic [CW-1:0]        ptr_q, ptr_d;
  logic [CW-1:0]        pos_q;
  logic [CW-1:0]        wp_q;
  logic                 found_q;
  logic [STAT_W-1:0]    res_status_q;
  logic [IDX_W-1:0]     res_index_q, res_index_d;
  logic                 out_valid_q;
  logic [STAT_W-1:0]    out_status_q;
  logic [IDX_W-1:0]     out_index_q;
  logic [IDX_W-1:0]     out_count_q;
  logic [CW-1:0]        ptr_m1;
  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic [DW-1:0]        wr_data;
  logic                 rd_en;
  logic [AW-1:0]        rd_addr;

  assign ptr_m1 = ptr_q - CW'(1);

  // Memory port: one write or one read a cycle, read data registered.
  always_comb begin
    wr_en   = cmd_i.wr_up | cmd_i.wr_ins | cmd_i.wr_dn;
    wr_addr = ptr_q[AW-1:0];
    wr_data = rdata_q;
    if (cmd_i.wr_ins) begin
      wr_addr = pos_q[AW-1:0];
      wr_data = value_q;
    end else if (cmd_i.wr_dn) begin
      wr_addr = wp_q[AW-1:0];
    end
    rd_en   = cmd_i.rd_ptr | cmd_i.rd_ptr_m1;
    rd_addr = cmd_i.rd_ptr_m1 ? ptr_m1[AW-1:0] : ptr_q[AW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  always_comb begin
    ptr_d = ptr_q;
    if (cmd_i.load) begin
      ptr_d = '0;
    end else if (cmd_i.ptr_to_count) begin
      ptr_d = count_q;
    end else if (cmd_i.ptr_inc) begin
      ptr_d = ptr_q + CW'(1);
    end else if (cmd_i.ptr_dec) begin
      ptr_d = ptr_m1;
    end
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.clr_count) begin
      count_d = '0;
    end else if (cmd_i.wr_ins) begin
      count_d = count_q + CW'(1);
    end else if (cmd_i.count_from_wp) begin
      count_d = wp_q;
    end
  end

  always_comb begin
    case (cmd_i.res_idx)
      IDX_ZERO:  res_index_d = '0;
      IDX_POS:   res_index_d = IDX_W'(pos_q);
      IDX_COUNT: res_index_d = IDX_W'(count_q);
      default:   res_index_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q <= ptr_d;
    if (cmd_i.load) begin
      mode_q  <= s_axis_tdata_i[MODE_W-1:0];
      value_q <= s_axis_tdata_i[MODE_W +: DW];
    end
    if (cmd_i.set_pos) begin
      pos_q   <= ptr_q;
      found_q <= !sts_o.at_end && sts_o.eq;
    end
    if (cmd_i.wp_from_pos) begin
      wp_q <= pos_q;
    end else if (cmd_i.wr_dn) begin
      wp_q <= wp_q + CW'(1);
    end
    if (cmd_i.set_res) begin
      res_status_q <= cmd_i.res_status;
      res_index_q  <= res_index_d;
    end
    if (cmd_i.emit) begin
      out_status_q <= res_status_q;
      out_index_q  <= res_index_q;
      out_count_q  <= IDX_W'(count_q);
    end
  end

  always_comb begin
    sts_o.mode       = mode_q;
    sts_o.found      = found_q;
    sts_o.at_end     = (ptr_q == count_q);
    sts_o.ge         = (rdata_q >= value_q);
    sts_o.eq         = (rdata_q == value_q);
    sts_o.full       = (count_q >= CW'(DEPTH));
    sts_o.ptr_gt_pos = (ptr_q > pos_q);
    sts_o.out_free   = !out_valid_q || m_axis_tready_i;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(M_TDATA_W - STAT_W - 2 * IDX_W){1'b0}},
                            out_count_q, out_index_q, out_status_q};

endmodule

// ===== hdl/sals_controller.sv =====
// Controller: sequences scan, shift and write steps for each request.
module sals_controller import sals_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      s_axis_tvalid_i,
  output logic      s_axis_tready_o,
  input  sals_sts_t sts_i,
  output sals_cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid_i) state_d = S_DISPATCH;
      end
      S_DISPATCH: begin
        case (sts_i.mode)
          MODE_INSERT, MODE_UNIQUE, MODE_DELETE, MODE_LOCATE: state_d = S_SCAN;
          default: state_d = S_FINISH;
        endcase
      end
      S_SCAN: begin
        state_d = sts_i.at_end ? S_DECIDE : S_SCAN_CMP;
      end
      S_SCAN_CMP: begin
        state_d = sts_i.ge ? S_DECIDE : S_SCAN;
      end
      S_DECIDE: begin
        case (sts_i.mode)
          MODE_LOCATE: state_d = S_FINISH;
          MODE_DELETE: state_d = sts_i.found ? S_RUN : S_FINISH;
          default: begin
            if ((sts_i.mode == MODE_UNIQUE && sts_i.found) || sts_i.full) begin
              state_d = S_FINISH;
            end else begin
              state_d = S_UP_CHK;
            end
          end
        endcase
      end
      S_UP_CHK: begin
        state_d = sts_i.ptr_gt_pos ? S_UP_WR : S_INS;
      end
      S_UP_WR:    state_d = S_UP_CHK;
      S_INS:      state_d = S_FINISH;
      S_RUN: begin
        state_d = sts_i.at_end ? S_DN_CHK : S_RUN_CMP;
      end
      S_RUN_CMP: begin
        state_d = sts_i.eq ? S_RUN : S_DN_WR;
      end
      S_DN_WR:    state_d = S_DN_CHK;
      S_DN_CHK: begin
        state_d = sts_i.at_end ? S_FINISH : S_DN_WR;
      end
      S_FINISH: begin
        if (sts_i.out_free) state_d = S_IDLE;
      end
      default:    state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o           = '0;
    s_axis_tready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        s_axis_tready_o = 1'b1;
        cmd_o.load      = s_axis_tvalid_i;
      end
      S_DISPATCH: begin
        case (sts_i.mode)
          MODE_INSERT, MODE_UNIQUE, MODE_DELETE, MODE_LOCATE: ;
          MODE_CLEAR: begin
            cmd_o.clr_count  = 1'b1;
            cmd_o.set_res    = 1'b1;
            cmd_o.res_status = ST_OK;
            cmd_o.res_idx    = IDX_ZERO;
          end
          default: begin
            cmd_o.set_res    = 1'b1;
            cmd_o.res_status = ST_OK;
            cmd_o.res_idx    = IDX_ZERO;
          end
        endcase
      end
      S_SCAN: begin
        if (sts_i.at_end) begin
          cmd_o.set_pos = 1'b1;
        end else begin
          cmd_o.rd_ptr = 1'b1;
        end
      end
      S_SCAN_CMP: begin
        if (sts_i.ge) begin
          cmd_o.set_pos = 1'b1;
        end else begin
          cmd_o.ptr_inc = 1'b1;
        end
      end
      S_DECIDE: begin
        case (sts_i.mode)
          MODE_LOCATE: begin
            cmd_o.set_res    = 1'b1;
            cmd_o.res_status = sts_i.found ? ST_OK : ST_MISS;
            cmd_o.res_idx    = sts_i.found ? IDX_POS : IDX_COUNT;
          end
          MODE_DELETE: begin
            if (sts_i.found) begin
              // step past the first copy, compaction writes from its slot
              cmd_o.ptr_inc     = 1'b1;
              cmd_o.wp_from_pos = 1'b1;
            end else begin
              cmd_o.set_res    = 1'b1;
              cmd_o.res_status = ST_MISS;
              cmd_o.res_idx    = IDX_COUNT;
            end
          end
          default: begin
            if (sts_i.mode == MODE_UNIQUE && sts_i.found) begin
              cmd_o.set_res    = 1'b1;
              cmd_o.res_status = ST_DUP;
              cmd_o.res_idx    = IDX_POS;
            end else if (sts_i.full) begin
              cmd_o.set_res    = 1'b1;
              cmd_o.res_status = ST_FULL;
              cmd_o.res_idx    = IDX_ZERO;
            end else begin
              cmd_o.ptr_to_count = 1'b1;
            end
          end
        endcase
      end
      S_UP_CHK: begin
        if (sts_i.ptr_gt_pos) cmd_o.rd_ptr_m1 = 1'b1;
      end
      S_UP_WR: begin
        cmd_o.wr_up   = 1'b1;
        cmd_o.ptr_dec = 1'b1;
      end
      S_INS: begin
        cmd_o.wr_ins     = 1'b1;
        cmd_o.set_res    = 1'b1;
        cmd_o.res_status = ST_OK;
        cmd_o.res_idx    = IDX_POS;
      end
      S_RUN: begin
        if (!sts_i.at_end) cmd_o.rd_ptr = 1'b1;
      end
      S_RUN_CMP: begin
        if (sts_i.eq) cmd_o.ptr_inc = 1'b1;
      end
      S_DN_WR: begin
        cmd_o.wr_dn   = 1'b1;
        cmd_o.ptr_inc = 1'b1;
      end
      S_DN_CHK: begin
        if (sts_i.at_end) begin
          cmd_o.count_from_wp = 1'b1;
          cmd_o.set_res       = 1'b1;
          cmd_o.res_status    = ST_OK;
          cmd_o.res_idx       = IDX_POS;
        end else begin
          cmd_o.rd_ptr = 1'b1;
        end
      end
      S_FINISH: begin
        cmd_o.emit = sts_i.out_free;
      end
      default: ;
    endcase
  end

endmodule

// ===== hdl/sorted_array_list_store_unit.sv =====
// Top level of the sorted list store: controller, datapath and checks.
//
// Holds up to DEPTH (32) signed 32-bit values in ascending order in a
// single-port memory and serves one request at a time: insert, insert if
// absent, delete every copy, locate, or clear. Every request returns one
// result item with status, index and the count afterwards. The memory
// does one read or one write per cycle. A request walks the entries while
// searching (up to the first entry not less than the value), then moves
// entries up on insert, or passes the copies and moves later entries down
// on delete. Clear and unused modes skip the search. A new item is taken
// once the previous one is finished, even while its result still waits in
// the output register. The memory needs no clearing after reset; only
// entries below the count are ever read.
`include "sorted_array_list_store_unit_assert.svh"

module sorted_array_list_store_unit import sals_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  logic [S_TDATA_W-1:0] s_axis_tdata_i,   // mode[2:0], value[34:3], zero pad
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  output logic [M_TDATA_W-1:0] m_axis_tdata_o    // status[1:0], index[7:2], count[13:8]
);

  sals_cmd_t cmd;
  sals_sts_t sts;

  sals_controller u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .sts_i           (sts),
    .cmd_o           (cmd)
  );

  sals_datapath u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  `SALS_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid_i && s_axis_tready_o, !s_axis_tready_o, "item accepted while previous request in progress")
  `SALS_ASSERT_NOW(a_emit_slot_free, cmd.emit, sts.out_free, "result loaded over a pending result")
  `SALS_ASSERT_NOW(a_one_mem_access, 1'b1, $onehot0({cmd.wr_up, cmd.wr_ins, cmd.wr_dn, cmd.rd_ptr, cmd.rd_ptr_m1}), "more than one memory access in a cycle")
  `SALS_ASSERT_NOW(a_no_insert_when_full, cmd.wr_ins, !sts.full, "insert into a full list")

endmodule

// ===== verif/sals_list_checker.sv =====
// Checker for the sorted list store: mirrors the list, predicts every reply and compares it.
`timescale 1ns / 100ps

module sals_list_checker import sals_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid_i,
  input  logic                 s_axis_tready_i,
  input  logic [S_TDATA_W-1:0] s_axis_tdata_i,
  input  logic                 m_axis_tvalid_i,
  input  logic                 m_axis_tready_i,
  input  logic [M_TDATA_W-1:0] m_axis_tdata_i,
  output int unsigned          mismatch_count_o,
  output int unsigned          pending_o
);

  // Last member sits in the low bits, matching the tdata layout: status, index, count.
  typedef struct packed {
    logic [IDX_W-1:0]  count;
    logic [IDX_W-1:0]  index;
    logic [STAT_W-1:0] status;
  } reply_t;

  logic signed [DW-1:0] held_q[$];
  reply_t               reply_q[$];

  function automatic int first_copy(logic signed [DW-1:0] v);
    int i;
    for (i = 0; i < held_q.size(); i++)
      if (held_q[i] == v) break;
    return i;
  endfunction

  function automatic int first_not_less(logic signed [DW-1:0] v);
    int i;
    for (i = 0; i < held_q.size(); i++)
      if (held_q[i] >= v) break;
    return i;
  endfunction

  // Apply one request to the mirrored list and return the reply it must produce.
  function automatic reply_t apply_request(logic [MODE_W-1:0] mode, logic signed [DW-1:0] v);
    reply_t r;
    int     p;
    r = '0;
    r.status = ST_OK;
    case (mode)
      MODE_INSERT, MODE_UNIQUE: begin
        p = first_copy(v);
        // The duplicate check wins over the full check.
        if (mode == MODE_UNIQUE && p < held_q.size()) begin
          r.status = ST_DUP;
          r.index  = IDX_W'(p);
        end else if (held_q.size() >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          p = first_not_less(v);
          held_q.insert(p, v);
          r.index = IDX_W'(p);
        end
      end
      MODE_DELETE, MODE_LOCATE: begin
        p = first_copy(v);
        if (p >= held_q.size()) begin
          r.status = ST_MISS;
          r.index  = IDX_W'(held_q.size());
        end else begin
          r.index = IDX_W'(p);
          // Walk down from the top so adjacent copies are all removed.
          if (mode == MODE_DELETE)
            for (int i = held_q.size() - 1; i >= p; i--)
              if (held_q[i] == v) held_q.delete(i);
        end
      end
      MODE_CLEAR: held_q.delete();
      default: ;
    endcase
    r.count = IDX_W'(held_q.size());
    return r;
  endfunction

  task automatic flag_error(string msg);
    mismatch_count_o++;
    if (mismatch_count_o <= 10) $display("%0t: %s", $realtime, msg);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    reply_t got;
    reply_t want;
    if (!rst_ni) begin
      held_q.delete();
      reply_q.delete();
      mismatch_count_o = 0;
    end else begin
      // Retire the oldest reply before queuing a new one: a reply never belongs
      // to the request accepted on the same edge.
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got = m_axis_tdata_i[$bits(reply_t)-1:0];
        if (reply_q.size() == 0) begin
          flag_error($sformatf("reply with nothing pending: status %0d index %0d count %0d",
                               got.status, got.index, got.count));
        end else begin
          want = reply_q.pop_front();
          if (got.status !== want.status || got.index !== want.index ||
              got.count !== want.count)
            flag_error($sformatf(
              "reply differs: expected status %0d index %0d count %0d, got %0d %0d %0d",
              want.status, want.index, want.count, got.status, got.index, got.count));
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i)
        reply_q.push_back(apply_request(s_axis_tdata_i[MODE_W-1:0],
                                        s_axis_tdata_i[MODE_W +: DW]));
    end
    pending_o = reply_q.size();
  end

endmodule

// ===== verif/tb_sorted_array_list_store_unit.sv =====
// Testbench top for the sorted list store: clock, reset, request traffic and verdict.
`timescale 1ns / 100ps

module tb_sorted_array_list_store_unit;
  import sals_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 700;
  localparam int unsigned HOLD_AFTER   = 250;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned TAIL_CYCLES  = 4 * DEPTH + 16;

  localparam logic signed [DW-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [DW-1:0] VAL_MAX = 32'sh7fff_ffff;
  localparam logic [MODE_W-1:0]    MODE_SPARE_FIRST = MODE_CLEAR + 3'd1;

  typedef enum int unsigned {PH_FILL, PH_MIX, PH_DRAIN} phase_e;

  logic                 clk;
  logic                 rst_n;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata;
  logic                 m_tvalid;
  logic                 m_tready;
  logic [M_TDATA_W-1:0] m_tdata;

  int unsigned mismatch_count;
  int unsigned pending;
  int unsigned sent_count;
  bit          calm;
  logic        hold_rx;

  logic signed [DW-1:0] pool [8];

  sorted_array_list_store_unit uut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  sals_list_checker checker_i (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .s_axis_tvalid_i  (s_tvalid),
    .s_axis_tready_i  (s_tready),
    .s_axis_tdata_i   (s_tdata),
    .m_axis_tvalid_i  (m_tvalid),
    .m_axis_tready_i  (m_tready),
    .m_axis_tdata_i   (m_tdata),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Cluster values so that duplicates, deletes and hits on locate are common.
  task automatic refresh_pool();
    logic signed [DW-1:0] base;
    int unsigned          spread;
    case ($urandom_range(0, 3))
      0:       base = VAL_MIN;
      1:       base = VAL_MAX - 7;
      2:       base = -4;
      default: base = $urandom;
    endcase
    spread = $urandom_range(1, 7);
    foreach (pool[i]) pool[i] = base + $urandom_range(0, spread);
  endtask

  function automatic logic [DW-1:0] pick_value();
    logic [DW-1:0] v;
    case ($urandom_range(0, 9))
      0: v = $urandom;
      1: begin
        case ($urandom_range(0, 3))
          0:       v = VAL_MIN;
          1:       v = VAL_MAX;
          2:       v = '0;
          default: v = '1;
        endcase
      end
      default: v = pool[$urandom_range(0, 7)];
    endcase
    return v;
  endfunction

  function automatic logic [MODE_W-1:0] pick_mode(phase_e kind);
    int unsigned         r;
    logic [MODE_W-1:0]   m;
    r = $urandom_range(0, 99);
    case (kind)
      PH_FILL: begin
        if (r < 85)      m = MODE_INSERT;
        else if (r < 95) m = MODE_UNIQUE;
        else             m = MODE_LOCATE;
      end
      PH_DRAIN: begin
        if (r < 20)      m = MODE_INSERT;
        else if (r < 65) m = MODE_DELETE;
        else if (r < 95) m = MODE_LOCATE;
        else             m = MODE_UNIQUE;
      end
      default: begin
        if (r < 30)      m = MODE_INSERT;
        else if (r < 50) m = MODE_UNIQUE;
        else if (r < 70) m = MODE_DELETE;
        else if (r < 92) m = MODE_LOCATE;
        else if (r < 96) m = MODE_CLEAR;
        else             m = MODE_SPARE_FIRST + MODE_W'($urandom_range(0, 2));
      end
    endcase
    return m;
  endfunction

  task automatic send_item(logic [MODE_W-1:0] mode, logic [DW-1:0] v);
    int unsigned gap;
    gap = calm ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(S_TDATA_W - MODE_W - DW){1'b0}}, v, mode};
    do @(posedge clk); while (!s_tready);
    sent_count++;
  endtask

  // Hold the request side until every reply has come back.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    @(posedge clk);
  endtask

  initial begin : stimulus
    phase_e      kind;
    int unsigned len;
    int unsigned target;
    bit          first;
    s_tvalid   <= 1'b0;
    s_tdata    <= '0;
    rst_n      <= 1'b0;
    calm        = 1'b0;
    sent_count  = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty list, extremes, adjacent copies, duplicate on unique, spare modes.
    send_item(MODE_CLEAR,  '0);
    send_item(MODE_LOCATE, 32'd5);
    send_item(MODE_DELETE, 32'd5);
    send_item(MODE_INSERT, VAL_MAX);
    send_item(MODE_INSERT, VAL_MIN);
    send_item(MODE_INSERT, '0);
    send_item(MODE_INSERT, '0);
    send_item(MODE_INSERT, '1);
    send_item(MODE_UNIQUE, '0);
    send_item(MODE_UNIQUE, 32'd1);
    send_item(MODE_LOCATE, VAL_MAX);
    send_item(MODE_LOCATE, 32'd7);
    send_item(MODE_INSERT, '0);
    send_item(MODE_DELETE, '0);
    send_item(MODE_DELETE, '0);
    send_item(MODE_SPARE_FIRST,         32'hdead_beef);
    send_item(MODE_SPARE_FIRST + 3'd1,  32'h0123_4567);
    send_item(MODE_SPARE_FIRST + 3'd2,  VAL_MIN);
    send_item(MODE_DELETE, VAL_MIN);
    send_item(MODE_DELETE, VAL_MAX);
    send_item(MODE_CLEAR,  '1);
    send_item(MODE_LOCATE, '1);
    wait_drained();

    target = sent_count + RANDOM_ITEMS;
    first  = 1'b1;
    while (sent_count < target) begin
      kind  = first ? PH_FILL : phase_e'($urandom_range(0, 2));
      first = 1'b0;
      calm  = ($urandom_range(0, 3) == 0);
      refresh_pool();
      len = (kind == PH_FILL) ? $urandom_range(40, 56) : $urandom_range(10, 50);
      if (kind == PH_FILL || $urandom_range(0, 2) == 0) send_item(MODE_CLEAR, $urandom);
      repeat (len) send_item(pick_mode(kind), pick_value());
      if ($urandom_range(0, 3) == 0) wait_drained();
    end

    s_tvalid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending == 0) begin
      $display("sorted_array_list_store_unit: match");
    end else begin
      $display("sorted_array_list_store_unit: mismatch");
    end
    $finish;
  end

  initial begin : receiver
    int unsigned gap;
    m_tready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      gap = calm ? 0 : $urandom_range(0, 5);
      if (gap > 0 || hold_rx) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
        while (hold_rx) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!(m_tvalid && m_tready));
    end
  end

  // Stall replies for a long stretch while requests keep coming, so the block backs up.
  initial begin : hold_off
    hold_rx <= 1'b0;
    wait (sent_count >= HOLD_AFTER);
    @(posedge clk);
    hold_rx <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_rx <= 1'b0;
  end

  initial begin : watchdog
    #10_000_000;
    $display("sorted_array_list_store_unit: mismatch");
    $finish;
  end

endmodule
